// ----- hdl/bfr_pkg.sv -----
package bfr_pkg;

  localparam logic [7:0] START_BYTE = 8'h21;
  localparam logic [7:0] SIGNATURE_BYTE = 8'h10;
  localparam logic [7:0] CMD_FRAME_LEN = 8'd2;

  localparam logic [7:0] CMD_ERASE = 8'h41;
  localparam logic [7:0] CMD_WRITE = 8'h42;
  localparam logic [7:0] CMD_BANK = 8'h43;
  localparam logic [7:0] CMD_START_TO = 8'h44;
  localparam logic [7:0] CMD_READ = 8'h45;
  localparam logic [7:0] CMD_STOP_TO = 8'h46;
  localparam logic [7:0] CMD_SIG = 8'h48;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_DATA
  } phase_t;

  typedef enum logic [3:0] {
    ACT_ACK      = 4'd0,
    ACT_NACK     = 4'd1,
    ACT_ERASE    = 4'd2,
    ACT_WRITE    = 4'd3,
    ACT_BANK     = 4'd4,
    ACT_START_TO = 4'd5,
    ACT_READ     = 4'd6,
    ACT_STOP_TO  = 4'd7,
    ACT_SIG      = 4'd8,
    ACT_FILL     = 4'd9
  } action_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_RD0,
    E_RD1,
    E_DEC,
    E_CSEND,
    E_W0,
    E_W1,
    E_W2,
    E_WSEND,
    E_FIN
  } emit_state_t;

  typedef struct packed {
    logic [7:0] length;
    logic [7:0] command;
    logic       check_ok;
  } frame_info_t;

endpackage

// ----- hdl/bfr_store.sv -----
module bfr_store #(
  parameter int DEPTH = 67,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/bfr_parse.sv -----
module bfr_parse import bfr_pkg::*; #(
  parameter int DEPTH = 67,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          beat,
  input  logic          mode,
  input  logic [7:0]    rx_byte,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          done,
  output frame_info_t   info
);

  localparam logic [7:0] DEPTH_B = 8'(DEPTH);

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cmd_r   <= '0;
      xor_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    done      = 1'b0;
    if (beat) begin
      if (mode) begin
        // timeout drops any frame in progress
        phase_nxt = PH_HUNT;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (rx_byte == START_BYTE) begin
              xor_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            len_nxt   = rx_byte;
            xor_nxt   = rx_byte;
            phase_nxt = PH_CMD;
          end
          PH_CMD: begin
            cmd_nxt   = rx_byte;
            xor_nxt   = xor_r ^ rx_byte;
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            xor_nxt = xor_r ^ rx_byte;
            wr_en   = (cnt_r < DEPTH_B);
            if (cnt_r == len_r) begin
              phase_nxt = PH_HUNT;
              done      = 1'b1;
            end else begin
              cnt_nxt = cnt_r + 8'd1;
            end
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  assign wr_addr       = cnt_r[AW-1:0];
  assign wr_data       = rx_byte;
  assign info.length   = len_r;
  assign info.command  = cmd_r;
  assign info.check_ok = ((xor_r ^ rx_byte) == 8'd0);

endmodule

// ----- hdl/bfr_emit.sv -----
module bfr_emit import bfr_pkg::*; #(
  parameter int WRITE_FRAME_LEN = 66,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  frame_info_t   info,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          busy,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [3:0]    out_action,
  output logic [15:0]   out_address,
  output logic [15:0]   out_word,
  output logic          out_bank,
  output logic          out_last
);

  localparam logic [7:0]  WFL_B = 8'(WRITE_FRAME_LEN);
  localparam logic [AW:0] WFL_W = (AW+1)'(WRITE_FRAME_LEN);

  emit_state_t   state_r, state_nxt;
  frame_info_t   info_r, info_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic          bank_r, bank_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          ovalid_r, ovalid_nxt;
  action_t       oact_r, oact_nxt;
  logic [15:0]   oaddr_r, oaddr_nxt;
  logic [15:0]   oword_r, oword_nxt;
  logic          obank_r, obank_nxt;
  logic          olast_r, olast_nxt;
  logic [15:0]   addr_inc;
  logic          last_fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= E_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    info_r  <= info_nxt;
    lo_r    <= lo_nxt;
    bank_r  <= bank_nxt;
    addr_r  <= addr_nxt;
    idx_r   <= idx_nxt;
    oact_r  <= oact_nxt;
    oaddr_r <= oaddr_nxt;
    oword_r <= oword_nxt;
    obank_r <= obank_nxt;
    olast_r <= olast_nxt;
  end

  // one adder steps the fill address for every word
  assign addr_inc  = addr_r + 16'd2;
  assign last_fill = ({1'b0, idx_r} + (AW+1)'(2)) >= WFL_W;

  always_comb begin
    state_nxt  = state_r;
    info_nxt   = info_r;
    lo_nxt     = lo_r;
    bank_nxt   = bank_r;
    addr_nxt   = addr_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    oact_nxt   = oact_r;
    oaddr_nxt  = oaddr_r;
    oword_nxt  = oword_r;
    obank_nxt  = obank_r;
    olast_nxt  = olast_r;
    rd_addr    = idx_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          info_nxt  = info;
          state_nxt = E_RD0;
        end
      end
      E_RD0: begin
        rd_addr   = '0;
        state_nxt = E_RD1;
      end
      E_RD1: begin
        rd_addr   = AW'(1);
        lo_nxt    = rd_data;
        bank_nxt  = (rd_data != 8'd0);
        state_nxt = E_DEC;
      end
      E_DEC: begin
        addr_nxt   = {rd_data, lo_r};
        ovalid_nxt = 1'b1;
        oact_nxt   = ACT_NACK;
        oaddr_nxt  = '0;
        oword_nxt  = '0;
        obank_nxt  = 1'b0;
        olast_nxt  = 1'b1;
        state_nxt  = E_FIN;
        priority if (!info_r.check_ok) begin
          state_nxt = E_FIN;
        end else if (info_r.length == CMD_FRAME_LEN) begin
          olast_nxt = 1'b0;
          state_nxt = E_CSEND;
          unique case (info_r.command)
            CMD_ERASE: begin
              oact_nxt  = ACT_ERASE;
              oaddr_nxt = {rd_data, lo_r};
            end
            CMD_WRITE: begin
              oact_nxt  = ACT_WRITE;
              oaddr_nxt = {rd_data, lo_r};
            end
            CMD_BANK: begin
              oact_nxt  = ACT_BANK;
              obank_nxt = bank_r;
            end
            CMD_START_TO: oact_nxt = ACT_START_TO;
            CMD_READ: begin
              oact_nxt  = ACT_READ;
              oaddr_nxt = {rd_data, lo_r};
            end
            CMD_STOP_TO: oact_nxt = ACT_STOP_TO;
            CMD_SIG: begin
              oact_nxt  = ACT_SIG;
              oword_nxt = {8'd0, SIGNATURE_BYTE};
            end
            default: begin
              oact_nxt  = ACT_NACK;
              olast_nxt = 1'b1;
              state_nxt = E_FIN;
            end
          endcase
        end else if (info_r.length == WFL_B) begin
          ovalid_nxt = 1'b0;
          idx_nxt    = AW'(2);
          state_nxt  = E_W0;
        end else begin
          state_nxt = E_FIN;
        end
      end
      E_CSEND: begin
        if (out_ready) begin
          oact_nxt  = ACT_ACK;
          oaddr_nxt = '0;
          oword_nxt = '0;
          obank_nxt = 1'b0;
          olast_nxt = 1'b1;
          state_nxt = E_FIN;
        end
      end
      E_W0: begin
        rd_addr   = idx_r;
        state_nxt = E_W1;
      end
      E_W1: begin
        rd_addr   = idx_r + AW'(1);
        lo_nxt    = rd_data;
        state_nxt = E_W2;
      end
      E_W2: begin
        ovalid_nxt = 1'b1;
        oact_nxt   = ACT_FILL;
        oaddr_nxt  = addr_r;
        oword_nxt  = {rd_data, lo_r};
        obank_nxt  = 1'b0;
        olast_nxt  = 1'b0;
        state_nxt  = E_WSEND;
      end
      E_WSEND: begin
        if (out_ready) begin
          addr_nxt = addr_inc;
          idx_nxt  = idx_r + AW'(2);
          if (last_fill) begin
            oact_nxt  = ACT_ACK;
            oaddr_nxt = '0;
            oword_nxt = '0;
            olast_nxt = 1'b1;
            state_nxt = E_FIN;
          end else begin
            ovalid_nxt = 1'b0;
            state_nxt  = E_W0;
          end
        end
      end
      E_FIN: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = E_IDLE;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  assign busy        = (state_r != E_IDLE);
  assign out_valid   = ovalid_r;
  assign out_action  = oact_r;
  assign out_address = oaddr_r;
  assign out_word    = oword_r;
  assign out_bank    = obank_r;
  assign out_last    = olast_r;

endmodule

// ----- hdl/boot_frame_receiver_core.sv -----
// a byte that closes no frame is taken while idle and gives no result
// after a closing byte the address bytes are read (E_RD0, E_RD1) and decoded
// (E_DEC) before the first beat; each fill of a write frame waits for the one
// before to be taken and its two bytes from the one store read port; ack is last
// in_tready stays low until the ack or nack beat of the frame is taken
// reset (rst_n low, synchronous) returns to hunting for the start byte
module boot_frame_receiver_core import bfr_pkg::*; #(
  parameter int WRITE_FRAME_LEN = 66
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // address, data_word, high_bank, zero pad
  output logic [3:0]  out_tuser,  // action
  output logic        out_tlast
);

  localparam int STORE_DEPTH = WRITE_FRAME_LEN + 1;
  localparam int AW = $clog2(STORE_DEPTH);

  logic          beat;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          done;
  frame_info_t   info;
  logic [3:0]    o_action;
  logic [15:0]   o_address;
  logic [15:0]   o_word;
  logic          o_bank;

  assign in_tready = !busy;
  assign beat      = in_tvalid && in_tready;

  bfr_parse #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .mode    (in_tuser),
    .rx_byte (in_tdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .done    (done),
    .info    (info)
  );

  bfr_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfr_emit #(
    .WRITE_FRAME_LEN (WRITE_FRAME_LEN),
    .AW              (AW)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (done),
    .info        (info),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .busy        (busy),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_action  (o_action),
    .out_address (o_address),
    .out_word    (o_word),
    .out_bank    (o_bank),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'b0000000, o_bank, o_word, o_address};
  assign out_tuser = o_action;

endmodule
